FILE: hw/rtl/rmr_pkg.sv
// Shared constants and types for the ROI mean range block.
`timescale 1ns / 1ps
`default_nettype none
package rmr_pkg;

  localparam int MAX_ROI_SIDE_DEF = 64;
  localparam int MAX_DIM_DEF      = 4096;

  localparam int COORD_W   = 16;
  localparam int MAG_W     = 16;
  localparam int SQSUM_W   = 32;
  localparam int ROOT_W    = 16;
  localparam int ROOT_IT_W = $clog2(ROOT_W);
  localparam int MEAN_W    = 16;
  localparam int USED_W    = 13;

  localparam int DIM_CFG_W = 13;
  localparam int ROI_CFG_W = 7;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROI    = 2'd2;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [ROI_CFG_W-1:0] ROI_RST    = 7'd40;

  // Per-transfer control for the position counters
  typedef struct packed {
    logic adv;
    logic clear;
  } rmr_step_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmr_win.sv
// Column/row counters and centered window membership test.
`timescale 1ns / 1ps
`default_nettype none
module rmr_win #(
  parameter int MAX_DIM      = rmr_pkg::MAX_DIM_DEF,
  parameter int MAX_ROI_SIDE = rmr_pkg::MAX_ROI_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rmr_pkg::DIM_CFG_W-1:0]  width_cfg,
  input  logic [rmr_pkg::DIM_CFG_W-1:0]  height_cfg,
  input  logic [rmr_pkg::ROI_CFG_W-1:0]  roi_cfg,
  input  rmr_pkg::rmr_step_t             step,
  output logic                           in_win
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = $clog2(MAX_ROI_SIDE + 1);
  localparam int EW = ((DW > SW) ? DW : SW) + 1;

  function automatic logic [DW-1:0] clamp_dim(input logic [rmr_pkg::DIM_CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
    else r = DW'(v);
    return r;
  endfunction

  function automatic logic in_span(input logic [DW-1:0] pos, input logic [DW-1:0] lim,
                                   input logic [SW-1:0] half);
    logic [EW-1:0] p;
    logic [EW-1:0] c;
    logic [EW-1:0] h;
    p = EW'(pos);
    c = EW'(lim >> 1);
    h = EW'(half);
    return (p + h >= c) && (p < c + h);
  endfunction

  logic [CW-1:0] col_r, row_r;
  logic [CW-1:0] col_nxt, row_nxt;
  logic [DW-1:0] w, h, col_eff, row_eff, col_inc, row_inc;
  logic [SW-1:0] side, half;

  always_comb begin
    w = clamp_dim(width_cfg);
    h = clamp_dim(height_cfg);
    side = (32'(roi_cfg) > MAX_ROI_SIDE) ? SW'(MAX_ROI_SIDE) : SW'(roi_cfg);
    half = side >> 1;
    col_eff = (DW'(col_r) >= w) ? '0 : DW'(col_r);
    row_eff = (DW'(row_r) >= h) ? '0 : DW'(row_r);
    in_win = in_span(col_eff, w, half) && in_span(row_eff, h, half);
    col_inc = col_eff + DW'(1);
    row_inc = row_eff + DW'(1);
    if (col_inc >= w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h) ? '0 : CW'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
      row_nxt = CW'(row_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step.clear) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step.adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rmr_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmr_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rmr_pkg::SQSUM_W-1:0]   radicand,
  output logic                          done,
  output logic [rmr_pkg::ROOT_W-1:0]    root
);

  localparam int RW = rmr_pkg::ROOT_W;
  localparam int QW = rmr_pkg::SQSUM_W;
  localparam int IW = rmr_pkg::ROOT_IT_W;
  localparam logic [IW-1:0] IT_LAST = IW'(RW - 1);

  logic [QW-1:0] rad_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] root_r;
  logic [IW-1:0] it_r;
  logic          run_r, done_r;

  logic [RW+2:0] rem_sh, trial;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[QW-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        it_r   <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        root_r <= {root_r[RW-2:0], ge};
        it_r   <= it_r + 1'b1;
        if (it_r == IT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rmr_div.sv
// Bit-serial restoring divider for the frame mean.
`timescale 1ns / 1ps
`default_nettype none
module rmr_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int IW = $clog2(NUM_W);
  localparam logic [IW-1:0] IT_LAST = IW'(NUM_W - 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [IW-1:0]    it_r;
  logic             run_r, done_r;

  logic [DEN_W:0] rem_sh;
  logic           ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        it_r  <= '0;
        num_r <= num;
        den_r <= den;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
        num_r <= {num_r[NUM_W-2:0], ge};
        it_r  <= it_r + 1'b1;
        if (it_r == IT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

FILE: hw/rtl/roi_mean_range_from_points_top.sv
// Top level: mean Euclidean range over a centered window of an organized cloud.
//
//   port group   dir   transfer rule
//   in_*         in    in_valid & in_ready, one point per transfer
//   out_*        out   out_valid & out_ready, one result per end of frame
//   APB          in    psel & penable & pwrite & pready, registers at 0x0/0x4/0x8
//
// A point outside the window or rejected is consumed in S_IDLE. A kept point has
// each coordinate squared in turn on one 16x16 multiplier, then passes through
// the two-bits-per-cycle square root. An end-of-frame point then also runs the
// bit-serial divider. The result sits in an output register, so the next frame
// starts while it waits. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module roi_mean_range_from_points_top #(
  parameter int MAX_ROI_SIDE = rmr_pkg::MAX_ROI_SIDE_DEF,
  parameter int MAX_DIM      = rmr_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rmr_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [rmr_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [rmr_pkg::COORD_W-1:0]  in_point_z,
  input  logic                                in_point_finite,
  input  logic                                in_end_of_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rmr_pkg::MEAN_W-1:0]          out_mean_distance,
  output logic [rmr_pkg::USED_W-1:0]          out_points_used,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rmr_pkg::APB_AW-1:0]          paddr,
  input  logic [rmr_pkg::APB_DW-1:0]          pwdata,
  output logic [rmr_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int CAP   = MAX_ROI_SIDE * MAX_ROI_SIDE;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int SUM_W = CNT_W + rmr_pkg::ROOT_W;
  localparam int MW    = rmr_pkg::MAG_W;
  localparam int QW    = rmr_pkg::SQSUM_W;
  localparam logic [1:0] SQ_LAST = 2'd2;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_DIVGO, S_DIV, S_OUT} state_t;

  function automatic logic [MW-1:0] mag(input logic signed [rmr_pkg::COORD_W-1:0] v);
    return v[rmr_pkg::COORD_W-1] ? MW'(-v) : MW'(v);
  endfunction

  state_t state_r;
  logic [1:0] sq_cnt_r;
  logic [MW-1:0] mx_r, my_r, mz_r;
  logic eof_r;
  logic [QW-1:0] acc_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic out_valid_r;
  logic [rmr_pkg::MEAN_W-1:0] mean_r;
  logic [rmr_pkg::USED_W-1:0] used_r;
  logic [rmr_pkg::DIM_CFG_W-1:0] width_r, height_r;
  logic [rmr_pkg::ROI_CFG_W-1:0] roi_r;

  logic accept, keep, in_win, apb_wr;
  logic [MW-1:0] mag_sel;
  logic [QW-1:0] prod, acc_nxt;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic sqrt_start, sqrt_done, div_start, div_done, out_load;
  logic [rmr_pkg::ROOT_W-1:0] root;
  logic [SUM_W-1:0] quot;
  rmr_pkg::rmr_step_t step;
  logic [rmr_pkg::REG_IDX_W-1:0] reg_idx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign step     = '{adv: accept, clear: accept && in_end_of_frame};
  assign keep     = in_win && in_point_finite && (in_point_x != '0) && (in_point_y != '0) &&
                    (in_point_z != '0) && (32'(cnt_r) < CAP);

  always_comb begin
    case (sq_cnt_r)
      2'd0:    mag_sel = mx_r;
      2'd1:    mag_sel = my_r;
      default: mag_sel = mz_r;
    endcase
  end

  assign prod       = QW'(mag_sel) * QW'(mag_sel);
  assign acc_nxt    = acc_r + prod;
  assign sqrt_start = (state_r == S_SQ) && (sq_cnt_r == SQ_LAST);
  assign div_start  = (state_r == S_DIVGO);
  assign sum_nxt    = sum_r + SUM_W'(root);
  assign cnt_nxt    = cnt_r + 1'b1;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign reg_idx = paddr[rmr_pkg::APB_AW-1:2];
  assign apb_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      rmr_pkg::REG_WIDTH:  prdata = rmr_pkg::APB_DW'(width_r);
      rmr_pkg::REG_HEIGHT: prdata = rmr_pkg::APB_DW'(height_r);
      rmr_pkg::REG_ROI:    prdata = rmr_pkg::APB_DW'(roi_r);
      default:             prdata = '0;
    endcase
  end

  rmr_win #(
    .MAX_DIM      (MAX_DIM),
    .MAX_ROI_SIDE (MAX_ROI_SIDE)
  ) u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .roi_cfg    (roi_r),
    .step       (step),
    .in_win     (in_win)
  );

  rmr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_nxt),
    .done     (sqrt_done),
    .root     (root)
  );

  rmr_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sq_cnt_r    <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      width_r     <= rmr_pkg::WIDTH_RST;
      height_r    <= rmr_pkg::HEIGHT_RST;
      roi_r       <= rmr_pkg::ROI_RST;
    end else begin
      if (apb_wr) begin
        case (reg_idx)
          rmr_pkg::REG_WIDTH:  width_r  <= pwdata[rmr_pkg::DIM_CFG_W-1:0];
          rmr_pkg::REG_HEIGHT: height_r <= pwdata[rmr_pkg::DIM_CFG_W-1:0];
          rmr_pkg::REG_ROI:    roi_r    <= pwdata[rmr_pkg::ROI_CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mx_r     <= mag(in_point_x);
            my_r     <= mag(in_point_y);
            mz_r     <= mag(in_point_z);
            eof_r    <= in_end_of_frame;
            acc_r    <= '0;
            sq_cnt_r <= '0;
            if (keep) state_r <= S_SQ;
            else if (in_end_of_frame) state_r <= S_DIVGO;
          end
        end
        S_SQ: begin
          acc_r    <= acc_nxt;
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sqrt_start) state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            sum_r   <= sum_nxt;
            cnt_r   <= cnt_nxt;
            state_r <= eof_r ? S_DIVGO : S_IDLE;
          end
        end
        S_DIVGO: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            mean_r  <= (cnt_r == '0) ? '0 : rmr_pkg::MEAN_W'(quot);
            used_r  <= rmr_pkg::USED_W'(cnt_r);
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_distance = mean_r;
  assign out_points_used   = used_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) 32'(cnt_r) <= CAP)
    else $error("kept count above cap");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (64'(root) * 64'(root) <= 64'(acc_r)) &&
                  (64'(acc_r) < (64'(root) + 64'd1) * (64'(root) + 64'd1)))
    else $error("square root not floor");

  a_mean_floor: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (cnt_r == '0) ||
                 ((64'(quot) * 64'(cnt_r) <= 64'(sum_r)) &&
                  (64'(sum_r) < (64'(quot) + 64'd1) * 64'(cnt_r))))
    else $error("mean quotient wrong");
`endif

endmodule
`default_nettype wire
